// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the flow statistics table.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("flow table check failed");

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("flow table check failed");

`endif

// ===== design/ufst_pkg.sv =====
// Package for the flow statistics table: types, codes, widths and helpers.
// No dependencies; imported by every module of the block except ufst_ram.
`timescale 1ns / 1ps
package ufst_pkg;

  localparam int PORT_ENTRIES_DEF   = 8;
  localparam int DESTS_PER_PORT_DEF = 4;

  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 280;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_PORT   = 2'd1,
    KIND_DEST   = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PORT_FULL = 2'd1,
    ST_DEST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_UPDATE, S_EMPTY, S_PORT_CHK, S_PORT_EMIT,
    S_DEST_CHK, S_DEST_EMIT, S_CLEAR
  } state_t;

  // Traffic counters of one entry
  typedef struct packed {
    logic [63:0] rb;
    logic [31:0] rp;
    logic [63:0] sb;
    logic [31:0] sp;
  } ctr_t;

  localparam int CTR_W  = $bits(ctr_t);
  localparam int PORT_W = CTR_W + 32;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic lookup;
    logic update;
    logic emit_empty;
    logic dump_start;
    logic rd_port;
    logic emit_port;
    logic step_port;
    logic rd_dest;
    logic emit_dest;
    logic step_dest;
    logic clear_all;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic any_port;
    logic port_used_cur;
    logic dest_used_cur;
    logic p_last;
    logic k_last;
  } stat_t;

  function automatic int bits_for(input int n);
    int r;
    r = 1;
    while ((1 << r) < n) r = r + 1;
    return r;
  endfunction

  function automatic ctr_t ctr_add(input ctr_t a, input ctr_t b);
    ctr_t s;
    s.rb = a.rb + b.rb;
    s.rp = a.rp + b.rp;
    s.sb = a.sb + b.sb;
    s.sp = a.sp + b.sp;
    return s;
  endfunction

endpackage

// ===== design/ufst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ufst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ufst_dp.sv =====
// Datapath of the flow statistics table: lookup, counter memories, dump walk
// and output register. Depends on ufst_pkg and ufst_ram.
`timescale 1ns / 1ps
module ufst_dp #(
  parameter int PORT_ENTRIES   = ufst_pkg::PORT_ENTRIES_DEF,
  parameter int DESTS_PER_PORT = ufst_pkg::DESTS_PER_PORT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ufst_pkg::IN_DATA_W-1:0]   s_tdata,
  input  ufst_pkg::cmd_t                   cmd,
  output ufst_pkg::stat_t                  stat,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ufst_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [1:0]                       m_tuser,
  output logic                             m_tlast
);
  import ufst_pkg::*;

  localparam int DN  = PORT_ENTRIES * DESTS_PER_PORT;
  localparam int PW  = bits_for(PORT_ENTRIES);
  localparam int KW  = bits_for(DESTS_PER_PORT);
  localparam int DAW = bits_for(DN);

  // Latched input word
  logic [15:0] in_port;
  logic [31:0] in_ip, in_sb, in_sp, in_rb, in_rp;

  // Key tables
  logic                      port_used [PORT_ENTRIES];
  logic [15:0]               port_key  [PORT_ENTRIES];
  logic [DESTS_PER_PORT-1:0] dest_used [PORT_ENTRIES];
  logic [31:0]               dest_addr [PORT_ENTRIES][DESTS_PER_PORT];

  // Lookup results
  logic          p_hit, p_free, d_hit, d_free;
  logic [PW-1:0] p_hit_idx, p_free_idx, sel_p_c;
  logic [KW-1:0] d_hit_idx, d_free_idx, sel_k_c;
  status_t       st_c;

  // Registered lookup outcome
  logic [PW-1:0] sel_p;
  logic [KW-1:0] sel_k;
  logic          new_port, new_dest;
  status_t       st_code;

  // Dump walk position
  logic [PW-1:0] dp_p;
  logic [KW-1:0] dp_k;

  // Memories
  logic [DAW-1:0]    port_unused_w;
  logic              port_re, dest_re, ram_we;
  logic [PW-1:0]     port_raddr;
  logic [DAW-1:0]    dest_raddr, dest_waddr;
  logic [PORT_W-1:0] port_rd, port_wr;
  logic [CTR_W-1:0]  dest_rd, dest_wr;
  ctr_t              din;

  // Output row
  logic                  out_load, out_free, last_port, last_dest, above_p, above_k;
  logic [OUT_DATA_W-1:0] row_data;
  kind_t                 row_kind;
  logic                  row_last;

  assign port_unused_w = '0;

  // Find the port by key and the lowest free slot
  always_comb begin
    p_hit = 1'b0;
    p_free = 1'b0;
    p_hit_idx = '0;
    p_free_idx = '0;
    for (int i = PORT_ENTRIES - 1; i >= 0; i--) begin
      if (port_used[i] && port_key[i] == in_port) begin
        p_hit = 1'b1;
        p_hit_idx = PW'(i);
      end
      if (!port_used[i]) begin
        p_free = 1'b1;
        p_free_idx = PW'(i);
      end
    end
  end

  assign sel_p_c = p_hit ? p_hit_idx : p_free_idx;

  // Find the destination within the chosen port's row
  always_comb begin
    d_hit = 1'b0;
    d_free = 1'b0;
    d_hit_idx = '0;
    d_free_idx = '0;
    for (int k = DESTS_PER_PORT - 1; k >= 0; k--) begin
      if (dest_used[sel_p_c][k] && dest_addr[sel_p_c][k] == in_ip) begin
        d_hit = 1'b1;
        d_hit_idx = KW'(k);
      end
      if (!dest_used[sel_p_c][k]) begin
        d_free = 1'b1;
        d_free_idx = KW'(k);
      end
    end
  end

  always_comb begin
    if (!p_hit && !p_free) begin
      st_c = ST_PORT_FULL;
    end else if (p_hit && !d_hit && !d_free) begin
      st_c = ST_DEST_FULL;
    end else begin
      st_c = ST_OK;
    end
    if (!p_hit) begin
      sel_k_c = '0;
    end else if (d_hit) begin
      sel_k_c = d_hit_idx;
    end else begin
      sel_k_c = d_free_idx;
    end
  end

  // Latch input word and lookup outcome
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_port <= s_tdata[15:0];
      in_ip   <= s_tdata[47:16];
      in_sb   <= s_tdata[79:48];
      in_sp   <= s_tdata[111:80];
      in_rb   <= s_tdata[143:112];
      in_rp   <= s_tdata[175:144];
    end
    if (cmd.lookup) begin
      sel_p    <= sel_p_c;
      sel_k    <= sel_k_c;
      new_port <= !p_hit;
      new_dest <= !p_hit || !d_hit;
      st_code  <= st_c;
    end
  end

  // Memory addressing
  assign port_re    = cmd.lookup || cmd.rd_port;
  assign dest_re    = cmd.lookup || cmd.rd_dest;
  assign port_raddr = cmd.lookup ? sel_p_c : dp_p;
  assign dest_raddr = cmd.lookup
                      ? DAW'(int'(sel_p_c) * DESTS_PER_PORT + int'(sel_k_c))
                      : DAW'(int'(dp_p) * DESTS_PER_PORT + int'(dp_k));
  assign dest_waddr = DAW'(int'(sel_p) * DESTS_PER_PORT + int'(sel_k));
  assign ram_we     = cmd.update && (st_code == ST_OK);

  // Add the record into both levels
  always_comb begin
    din.sb = {32'd0, in_sb};
    din.rb = {32'd0, in_rb};
    din.sp = in_sp;
    din.rp = in_rp;
    if (new_port) begin
      port_wr = {32'd1, din};
    end else begin
      port_wr = {port_rd[PORT_W-1:CTR_W] + 32'd1, ctr_add(ctr_t'(port_rd[CTR_W-1:0]), din)};
    end
    dest_wr = new_dest ? CTR_W'(din) : CTR_W'(ctr_add(ctr_t'(dest_rd), din));
  end

  ufst_ram #(.WIDTH(PORT_W), .DEPTH(PORT_ENTRIES), .AW(PW)) u_port_ram (
    .clk(clk), .we(ram_we), .waddr(sel_p), .wdata(port_wr),
    .re(port_re), .raddr(port_raddr), .rdata(port_rd)
  );

  ufst_ram #(.WIDTH(CTR_W), .DEPTH(DN), .AW(DAW)) u_dest_ram (
    .clk(clk), .we(ram_we), .waddr(dest_waddr | port_unused_w), .wdata(dest_wr),
    .re(dest_re), .raddr(dest_raddr), .rdata(dest_rd)
  );

  // Used bits: set on insert, drop all on reset and after a dump
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      for (int i = 0; i < PORT_ENTRIES; i++) begin
        port_used[i] <= 1'b0;
        dest_used[i] <= '0;
      end
    end else if (ram_we) begin
      if (new_port) begin
        port_used[sel_p] <= 1'b1;
        dest_used[sel_p] <= DESTS_PER_PORT'(1);
      end else if (new_dest) begin
        dest_used[sel_p][sel_k] <= 1'b1;
      end
    end
  end

  // Keys, written with the entry
  always_ff @(posedge clk) begin
    if (ram_we) begin
      if (new_port) begin
        port_key[sel_p] <= in_port;
      end
      if (new_dest) begin
        dest_addr[sel_p][sel_k] <= in_ip;
      end
    end
  end

  // Dump walk counters
  always_ff @(posedge clk) begin
    if (rst || cmd.dump_start) begin
      dp_p <= '0;
      dp_k <= '0;
    end else if (cmd.step_port) begin
      dp_p <= dp_p + 1'b1;
      dp_k <= '0;
    end else if (cmd.step_dest) begin
      if (stat.k_last) begin
        dp_k <= '0;
        if (!stat.p_last) begin
          dp_p <= dp_p + 1'b1;
        end
      end else begin
        dp_k <= dp_k + 1'b1;
      end
    end
  end

  // Look ahead for rows still to come
  always_comb begin
    above_p = 1'b0;
    above_k = 1'b0;
    for (int j = 0; j < PORT_ENTRIES; j++) begin
      if (j > int'(dp_p) && port_used[j]) above_p = 1'b1;
    end
    for (int j = 0; j < DESTS_PER_PORT; j++) begin
      if (j > int'(dp_k) && dest_used[dp_p][j]) above_k = 1'b1;
    end
  end

  assign last_port = !(|dest_used[dp_p]) && !above_p;
  assign last_dest = !above_k && !above_p;

  // Status to controller
  assign out_free = !m_tvalid || m_tready;
  always_comb begin
    stat.out_free      = out_free;
    stat.any_port      = 1'b0;
    for (int i = 0; i < PORT_ENTRIES; i++) begin
      if (port_used[i]) stat.any_port = 1'b1;
    end
    stat.port_used_cur = port_used[dp_p];
    stat.dest_used_cur = dest_used[dp_p][dp_k];
    stat.p_last        = (dp_p == PW'(PORT_ENTRIES - 1));
    stat.k_last        = (dp_k == KW'(DESTS_PER_PORT - 1));
  end

  // Build the outgoing row
  always_comb begin
    row_data = '0;
    row_kind = KIND_STATUS;
    row_last = 1'b0;
    if (cmd.update) begin
      row_data = {230'd0, in_ip, in_port, st_code};
      row_last = 1'b1;
    end else if (cmd.emit_empty) begin
      row_kind = KIND_EMPTY;
      row_last = 1'b1;
    end else if (cmd.emit_port) begin
      row_kind = KIND_PORT;
      row_data = {6'd0, port_rd[CTR_W-1:0], port_rd[PORT_W-1:CTR_W], 32'd0,
                  port_key[dp_p], ST_OK};
      row_last = last_port;
    end else begin
      row_kind = KIND_DEST;
      row_data = {6'd0, dest_rd, 32'd0, dest_addr[dp_p][dp_k], port_key[dp_p], ST_OK};
      row_last = last_dest;
    end
  end

  assign out_load = cmd.update || cmd.emit_empty || cmd.emit_port || cmd.emit_dest;

  // Output register: load a word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= row_data;
      m_tuser <= row_kind;
      m_tlast <= row_last;
    end
  end

endmodule

// ===== design/ufst_ctrl.sv =====
// Controller of the flow statistics table: sequences record updates and dumps.
// Depends on ufst_pkg.
`timescale 1ns / 1ps
module ufst_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            func,
  output logic            s_tready,
  input  ufst_pkg::stat_t stat,
  output ufst_pkg::cmd_t  cmd
);
  import ufst_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          if (func) begin
            cmd.dump_start = 1'b1;
            state_next = stat.any_port ? S_PORT_CHK : S_EMPTY;
          end else begin
            state_next = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (stat.out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PORT_CHK: begin
        if (stat.port_used_cur) begin
          cmd.rd_port = 1'b1;
          state_next = S_PORT_EMIT;
        end else if (stat.p_last) begin
          state_next = S_CLEAR;
        end else begin
          cmd.step_port = 1'b1;
        end
      end
      S_PORT_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_port = 1'b1;
          state_next = S_DEST_CHK;
        end
      end
      S_DEST_CHK: begin
        if (stat.dest_used_cur) begin
          cmd.rd_dest = 1'b1;
          state_next = S_DEST_EMIT;
        end else begin
          cmd.step_dest = 1'b1;
          if (stat.k_last) begin
            state_next = stat.p_last ? S_CLEAR : S_PORT_CHK;
          end
        end
      end
      S_DEST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_dest = 1'b1;
          cmd.step_dest = 1'b1;
          if (stat.k_last) begin
            state_next = stat.p_last ? S_CLEAR : S_PORT_CHK;
          end else begin
            state_next = S_DEST_CHK;
          end
        end
      end
      S_CLEAR: begin
        cmd.clear_all = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/udp_flow_stat_table_top.sv =====
// Record: the word is latched on acceptance, LOOKUP does the key compare and RAM read,
// then UPDATE does the counter update and loads the status word into the output register.
// One record at a time; next word accepted the cycle after the status word is loaded.
// Dump: a row takes CHK and EMIT, an empty slot CHK, then CLEAR; output stalls hold EMIT.
// Reset (synchronous, rst high) empties the table; counter RAMs are not cleared.
`timescale 1ns / 1ps
module udp_flow_stat_table_top #(
  parameter int PORT_ENTRIES   = ufst_pkg::PORT_ENTRIES_DEF,
  parameter int DESTS_PER_PORT = ufst_pkg::DESTS_PER_PORT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // dst_port, dst_ip, send_bytes, send_packets, recv_bytes, recv_packets
  input  logic [ufst_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status, port_out, ip_out, record_count, sent_pkts_total, sent_bytes_total,
  // recv_pkts_total, recv_bytes_total, zero fill
  output logic [ufst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // kind
  output logic [1:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);
  import ufst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ufst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_axis_tvalid), .func(s_axis_tuser),
    .s_tready(s_axis_tready), .stat(stat), .cmd(cmd)
  );

  ufst_dp #(.PORT_ENTRIES(PORT_ENTRIES), .DESTS_PER_PORT(DESTS_PER_PORT)) u_dp (
    .clk(clk), .rst(rst), .s_tdata(s_axis_tdata), .cmd(cmd), .stat(stat),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
    .m_tuser(m_axis_tuser), .m_tlast(m_axis_tlast)
  );

endmodule

// ===== design/ufst_chk.sv =====
// Port-level checker for the flow statistics table, bound to the top level.
// Depends on ufst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ufst_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [ufst_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ufst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser,
  input logic                            m_axis_tlast
);
  import ufst_pkg::*;

  // Stalled output word holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // One word in work at a time
  `ASSERT_NEXT(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Status and empty-dump words close their item
  `ASSERT_IMPL(a_single_last, clk, rst, m_axis_tvalid && (m_axis_tuser == KIND_STATUS || m_axis_tuser == KIND_EMPTY), m_axis_tlast)

  // Dump rows always report ok
  `ASSERT_IMPL(a_row_ok, clk, rst, m_axis_tvalid && m_axis_tuser != KIND_STATUS, m_axis_tdata[1:0] == ST_OK)

endmodule

bind udp_flow_stat_table_top ufst_chk u_chk (.*);
